// ===== design/dfs_topological_sort_core_macros.svh =====
// Assertion macros used by the checker file of the topological sort core.
`ifndef DFS_TOPOLOGICAL_SORT_CORE_MACROS_SVH
`define DFS_TOPOLOGICAL_SORT_CORE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define DFS_TOPO_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dfs_topological_sort_core: assertion failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define DFS_TOPO_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dfs_topological_sort_core: assertion failed");

`endif

// ===== design/dfs_topo_pkg.sv =====
// Shared types and constants of the depth-first topological sort core.
package dfs_topo_pkg;

    // Default store sizes
    localparam int MAX_NODES  = 64;
    localparam int MAX_DEGREE = 8;

    // Fixed field widths
    localparam int NODE_W       = 6;
    localparam int CMD_W        = 2;
    localparam int NODE_COUNT_W = 7;

    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    // Input item
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [NODE_W-1:0] node_index;
        logic              last_node;
        logic              edges_dropped;
    } t_out_item;

endpackage

// ===== design/dfs_topo_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dfs_topo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/dfs_topological_sort_core.sv =====
// Add edge: count read, then edge write; clear graph and command 3: taken while idle.
// Run: depth-first walk over the nodes in use and their stored successors, then results
// are read off the order stack as the output frees up; the block stalls its input
// until the last result sits in the output register. One sequencer drives the reads of the
// single-read RAMs for counts, successors, search frames and the order stack.
// Synchronous reset clears control, graph (all lists empty), flag; node_count = 64.
module dfs_topological_sort_core #(
    parameter int MAX_NODES  = dfs_topo_pkg::MAX_NODES,
    parameter int MAX_DEGREE = dfs_topo_pkg::MAX_DEGREE
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  dfs_topo_pkg::t_in_item                  i_in_item,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output dfs_topo_pkg::t_out_item                 o_out_item,
    input  logic                                    i_cfg_we,
    input  logic [dfs_topo_pkg::NODE_COUNT_W-1:0]   i_cfg_data
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int DW  = $clog2(MAX_NODES + 1);
    localparam int CW  = $clog2(MAX_DEGREE + 1);
    localparam int TD  = MAX_NODES * MAX_DEGREE;
    localparam int TAW = $clog2(TD);
    localparam int FW  = NW + 2 * CW;
    localparam int NCW = dfs_topo_pkg::NODE_COUNT_W;
    localparam int VW  = dfs_topo_pkg::NODE_W;

    typedef enum logic [3:0] {
        S_IDLE, S_ADD_WR, S_ROOT, S_LDCNT, S_STEP, S_EDGE, S_POP, S_ERD, S_EOUT
    } t_state;

    t_state                  r_state, n_state;
    logic [NCW-1:0]          r_node_count;
    logic                    r_overflow, n_overflow;
    logic [MAX_NODES-1:0]    r_cnt_valid, n_cnt_valid;
    logic [MAX_NODES-1:0]    r_visited, n_visited;
    logic [NW-1:0]           r_src, n_src;
    logic [VW-1:0]           r_dst, n_dst;
    logic                    r_src_ok, n_src_ok;
    logic [DW-1:0]           r_n, n_n;
    logic [DW-1:0]           r_root, n_root;
    logic [DW-1:0]           r_depth, n_depth;
    logic [DW-1:0]           r_pushed, n_pushed;
    logic [NW-1:0]           r_idx, n_idx;
    logic [NW-1:0]           r_cur_node, n_cur_node;
    logic [CW-1:0]           r_cur_pos, n_cur_pos;
    logic [CW-1:0]           r_cur_cnt, n_cur_cnt;
    logic                    r_out_valid, n_out_valid;
    dfs_topo_pkg::t_out_item r_out_item, n_out_item;

    // RAM ports
    logic           cnt_we, cnt_re;
    logic [NW-1:0]  cnt_waddr, cnt_raddr;
    logic [CW-1:0]  cnt_wdata, cnt_rdata;
    logic           tbl_we, tbl_re;
    logic [TAW-1:0] tbl_waddr, tbl_raddr;
    logic [VW-1:0]  tbl_rdata;
    logic           frm_we, frm_re;
    logic [NW-1:0]  frm_waddr, frm_raddr;
    logic [FW-1:0]  frm_wdata, frm_rdata;
    logic           ord_we, ord_re;
    logic [NW-1:0]  ord_waddr, ord_raddr;
    logic [NW-1:0]  ord_rdata;

    logic           in_xfer;
    logic [NCW-1:0] n_eff;
    logic [CW-1:0]  add_cnt;
    logic [NW-1:0]  w_node;
    logic           w_take;
    logic [DW-1:0]  depth_m1, depth_m2, pushed_m1;

    assign in_xfer   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Effective node count, clipped to the store size
    assign n_eff = (r_node_count > NCW'(MAX_NODES)) ? NCW'(MAX_NODES) : r_node_count;

    // Stored count of the source node; an invalid entry reads as empty
    assign add_cnt = r_cnt_valid[r_src] ? cnt_rdata : '0;

    // Successor just read: take it when in range and not yet visited
    assign w_node = tbl_rdata[NW-1:0];
    assign w_take = ({1'b0, tbl_rdata} < NCW'(r_n)) && !r_visited[w_node];

    assign depth_m1  = r_depth - DW'(1);
    assign depth_m2  = r_depth - DW'(2);
    assign pushed_m1 = r_pushed - DW'(1);

    // Sequencer next state and RAM controls
    always_comb begin
        n_state     = r_state;
        n_overflow  = r_overflow;
        n_cnt_valid = r_cnt_valid;
        n_visited   = r_visited;
        n_src       = r_src;
        n_dst       = r_dst;
        n_src_ok    = r_src_ok;
        n_n         = r_n;
        n_root      = r_root;
        n_depth     = r_depth;
        n_pushed    = r_pushed;
        n_idx       = r_idx;
        n_cur_node  = r_cur_node;
        n_cur_pos   = r_cur_pos;
        n_cur_cnt   = r_cur_cnt;
        n_out_item  = r_out_item;
        n_out_valid = r_out_valid && i_out_stall;

        cnt_we    = 1'b0;
        cnt_waddr = r_src;
        cnt_wdata = add_cnt + CW'(1);
        cnt_re    = 1'b0;
        cnt_raddr = i_in_item.from_node[NW-1:0];
        tbl_we    = 1'b0;
        tbl_waddr = TAW'(r_src) * TAW'(MAX_DEGREE) + TAW'(add_cnt);
        tbl_re    = 1'b0;
        tbl_raddr = TAW'(r_cur_node) * TAW'(MAX_DEGREE) + TAW'(r_cur_pos);
        frm_we    = 1'b0;
        frm_waddr = depth_m1[NW-1:0];
        frm_wdata = {r_cur_node, r_cur_pos, r_cur_cnt};
        frm_re    = 1'b0;
        frm_raddr = depth_m2[NW-1:0];
        ord_we    = 1'b0;
        ord_waddr = r_pushed[NW-1:0];
        ord_re    = 1'b0;
        ord_raddr = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    unique case (i_in_item.command)
                        dfs_topo_pkg::CMD_ADD: begin
                            // Fetch the source's count, write the edge next cycle
                            n_src    = i_in_item.from_node[NW-1:0];
                            n_dst    = i_in_item.to_node;
                            n_src_ok = {1'b0, i_in_item.from_node} < NCW'(MAX_NODES);
                            cnt_re   = 1'b1;
                            n_state  = S_ADD_WR;
                        end
                        dfs_topo_pkg::CMD_RUN: begin
                            n_n       = DW'(n_eff);
                            n_visited = '0;
                            n_root    = '0;
                            n_pushed  = '0;
                            n_state   = (n_eff == '0) ? S_IDLE : S_ROOT;
                        end
                        dfs_topo_pkg::CMD_CLEAR: begin
                            n_cnt_valid = '0;
                            n_overflow  = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_ADD_WR: begin
                // Store the edge, or flag it when the node's list is full
                if (r_src_ok) begin
                    if (add_cnt >= CW'(MAX_DEGREE)) begin
                        n_overflow = 1'b1;
                    end else begin
                        tbl_we              = 1'b1;
                        cnt_we              = 1'b1;
                        n_cnt_valid[r_src]  = 1'b1;
                    end
                end
                n_state = S_IDLE;
            end
            S_ROOT: begin
                // Next unvisited root, or start emitting when all are done
                if (r_root == r_n) begin
                    n_idx   = pushed_m1[NW-1:0];
                    n_state = S_ERD;
                end else if (r_visited[r_root[NW-1:0]]) begin
                    n_root = r_root + DW'(1);
                end else begin
                    n_visited[r_root[NW-1:0]] = 1'b1;
                    n_cur_node = r_root[NW-1:0];
                    n_cur_pos  = '0;
                    n_depth    = DW'(1);
                    cnt_re     = 1'b1;
                    cnt_raddr  = r_root[NW-1:0];
                    n_state    = S_LDCNT;
                end
            end
            S_LDCNT: begin
                n_cur_cnt = r_cnt_valid[r_cur_node] ? cnt_rdata : '0;
                n_state   = S_STEP;
            end
            S_STEP: begin
                if (r_cur_pos < r_cur_cnt) begin
                    // Read the next successor
                    tbl_re    = 1'b1;
                    n_cur_pos = r_cur_pos + CW'(1);
                    n_state   = S_EDGE;
                end else begin
                    // Node finished: push it, then pop the parent's frame or, at the root, go to the next root
                    ord_we   = 1'b1;
                    n_pushed = r_pushed + DW'(1);
                    n_depth  = depth_m1;
                    if (r_depth == DW'(1)) begin
                        n_root  = r_root + DW'(1);
                        n_state = S_ROOT;
                    end else begin
                        frm_re  = 1'b1;
                        n_state = S_POP;
                    end
                end
            end
            S_EDGE: begin
                // Descend into a taken successor, else back to the step; depth never exceeds the node count
                if (w_take) begin
                    n_visited[w_node] = 1'b1;
                    frm_we     = 1'b1;
                    n_cur_node = w_node;
                    n_cur_pos  = '0;
                    n_depth    = r_depth + DW'(1);
                    cnt_re     = 1'b1;
                    cnt_raddr  = w_node;
                    n_state    = S_LDCNT;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_POP: begin
                {n_cur_node, n_cur_pos, n_cur_cnt} = frm_rdata;
                n_state = S_STEP;
            end
            S_ERD: begin
                ord_re  = 1'b1;
                n_state = S_EOUT;
            end
            S_EOUT: begin
                // Load the output register once it is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid              = 1'b1;
                    n_out_item.node_index    = VW'(ord_rdata);
                    n_out_item.last_node     = (r_idx == '0);
                    n_out_item.edges_dropped = r_overflow;
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx - NW'(1);
                        n_state = S_ERD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= dfs_topo_pkg::NODE_COUNT_RESET;
            r_overflow   <= 1'b0;
            r_cnt_valid  <= '0;
            r_visited    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_overflow  <= n_overflow;
            r_cnt_valid <= n_cnt_valid;
            r_visited   <= n_visited;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
        end
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_src_ok   <= n_src_ok;
        r_n        <= n_n;
        r_root     <= n_root;
        r_depth    <= n_depth;
        r_pushed   <= n_pushed;
        r_idx      <= n_idx;
        r_cur_node <= n_cur_node;
        r_cur_pos  <= n_cur_pos;
        r_cur_cnt  <= n_cur_cnt;
        r_out_item <= n_out_item;
    end

    // Successor counts per node
    dfs_topo_ram #(.WIDTH(CW), .DEPTH(MAX_NODES)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    // Successor lists, MAX_DEGREE slots per node
    dfs_topo_ram #(.WIDTH(VW), .DEPTH(TD)) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (r_dst),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    // Parent search frames: node, next position, count
    dfs_topo_ram #(.WIDTH(FW), .DEPTH(MAX_NODES)) u_frm_ram (
        .i_clk   (i_clk),
        .i_we    (frm_we),
        .i_waddr (frm_waddr),
        .i_wdata (frm_wdata),
        .i_re    (frm_re),
        .i_raddr (frm_raddr),
        .o_rdata (frm_rdata)
    );

    // Post-order stack
    dfs_topo_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_ord_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (r_cur_node),
        .i_re    (ord_re),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

endmodule

// ===== design/dfs_topo_chk.sv =====
// Port-level checker for the topological sort core, bound to the core module.
`include "dfs_topological_sort_core_macros.svh"

module dfs_topo_chk (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input dfs_topo_pkg::t_in_item  i_in_item,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input dfs_topo_pkg::t_out_item o_out_item
);

    logic add_xfer;

    // Edge transfer on the input channel
    assign add_xfer = i_in_valid && !o_in_stall
                      && (i_in_item.command == dfs_topo_pkg::CMD_ADD);

    // Hold a stalled result
    `DFS_TOPO_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))

    // Stay busy while more results of a run remain
    `DFS_TOPO_ASSERT_IMP(a_busy_mid_order, o_out_valid && !o_out_item.last_node, o_in_stall)

    // An edge transfer is always followed by the busy write state
    `DFS_TOPO_ASSERT_NXT(a_add_busy, add_xfer, o_in_stall)

    // Nothing follows the final result of a run
    `DFS_TOPO_ASSERT_NXT(a_last_ends, o_out_valid && o_out_item.last_node && !i_out_stall, !o_out_valid)

endmodule

bind dfs_topological_sort_core dfs_topo_chk u_dfs_topo_chk (.*);

// ===== test/tb.sv =====
// Self-checking testbench for the depth-first topological sort core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CMD_W        = dfs_topo_pkg::CMD_W;
    localparam int NODE_W       = dfs_topo_pkg::NODE_W;
    localparam int NODE_COUNT_W = dfs_topo_pkg::NODE_COUNT_W;
    localparam int MAX_NODES    = dfs_topo_pkg::MAX_NODES;
    localparam int MAX_DEGREE   = dfs_topo_pkg::MAX_DEGREE;

    localparam logic [CMD_W-1:0] UNUSED_CMD = 2'd3;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 32;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int DIR_ROWS      = 23;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // One step of the directed sequence: an item (repeated) or a node count write
    typedef struct packed {
        t_row_kind                kind;
        dfs_topo_pkg::t_in_item   item;
        logic [3:0]               reps;
        logic [NODE_COUNT_W-1:0]  cfg_value;
        logic                     has_typed;
        logic [2:0]               typed_count;
        logic [0:3][NODE_W-1:0]   typed_nodes;
        logic                     typed_dropped;
    } t_dir_row;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    dfs_topo_pkg::t_in_item  in_item   = '0;
    logic                    out_stall = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [NODE_COUNT_W-1:0] cfg_data  = '0;
    logic                    in_stall;
    logic                    out_valid;
    dfs_topo_pkg::t_out_item out_item;

    // Predicted graph, flag and node count
    logic [NODE_W-1:0]       succ_list [MAX_NODES][MAX_DEGREE];
    int                      succ_count [MAX_NODES];
    bit                      degree_overflow = 1'b0;
    int                      nodes_in_use = int'(dfs_topo_pkg::NODE_COUNT_RESET);
    dfs_topo_pkg::t_out_item pending_order [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    t_dir_row dir_table [DIR_ROWS];

    dfs_topological_sort_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic dfs_topo_pkg::t_in_item make_item(input logic [CMD_W-1:0] cmd,
                                                         input logic [NODE_W-1:0] from_n,
                                                         input logic [NODE_W-1:0] to_n);
        dfs_topo_pkg::t_in_item it;
        it.command   = cmd;
        it.from_node = from_n;
        it.to_node   = to_n;
        return it;
    endfunction

    function automatic t_dir_row item_row(input logic [CMD_W-1:0] cmd,
                                          input logic [NODE_W-1:0] from_n,
                                          input logic [NODE_W-1:0] to_n,
                                          input logic [3:0] reps);
        t_dir_row row;
        row      = '0;
        row.kind = ROW_ITEM;
        row.item = make_item(cmd, from_n, to_n);
        row.reps = reps;
        return row;
    endfunction

    function automatic t_dir_row run_row(input logic typed, input logic [2:0] count,
                                         input logic [0:3][NODE_W-1:0] nodes,
                                         input logic dropped);
        t_dir_row row;
        row               = item_row(dfs_topo_pkg::CMD_RUN, '0, '0, 4'd1);
        row.has_typed     = typed;
        row.typed_count   = count;
        row.typed_nodes   = nodes;
        row.typed_dropped = dropped;
        return row;
    endfunction

    function automatic t_dir_row cfg_row(input logic [NODE_COUNT_W-1:0] value);
        t_dir_row row;
        row           = '0;
        row.kind      = ROW_CFG;
        row.cfg_value = value;
        return row;
    endfunction

    // Advance the predicted graph by one item and queue the order a run emits
    function automatic void apply_graph_command(input dfs_topo_pkg::t_in_item it);
        int limit_n;
        int pushed;
        int depth;
        int top;
        int v;
        int w;
        int post_order [MAX_NODES];
        int frame_at [MAX_NODES];
        int frame_next [MAX_NODES];
        bit seen [MAX_NODES];
        dfs_topo_pkg::t_out_item res;
        case (it.command)
            dfs_topo_pkg::CMD_ADD: begin
                if (succ_count[it.from_node] >= MAX_DEGREE) begin
                    degree_overflow = 1'b1;
                end else begin
                    succ_list[it.from_node][succ_count[it.from_node]] = it.to_node;
                    succ_count[it.from_node]++;
                end
            end
            dfs_topo_pkg::CMD_CLEAR: begin
                for (int n = 0; n < MAX_NODES; n++) succ_count[n] = 0;
                degree_overflow = 1'b0;
            end
            dfs_topo_pkg::CMD_RUN: begin
                limit_n = (nodes_in_use > MAX_NODES) ? MAX_NODES : nodes_in_use;
                pushed  = 0;
                for (int n = 0; n < MAX_NODES; n++) seen[n] = 1'b0;
                for (int r = 0; r < limit_n; r++) begin
                    if (!seen[r]) begin
                        seen[r]       = 1'b1;
                        frame_at[0]   = r;
                        frame_next[0] = 0;
                        depth         = 1;
                        // Walk successors in arrival order, post-order push on exit
                        while (depth > 0) begin
                            top = depth - 1;
                            v   = frame_at[top];
                            if (frame_next[top] < succ_count[v]) begin
                                w = int'(succ_list[v][frame_next[top]]);
                                frame_next[top]++;
                                if (w < limit_n && !seen[w] && depth < MAX_NODES) begin
                                    seen[w]           = 1'b1;
                                    frame_at[depth]   = w;
                                    frame_next[depth] = 0;
                                    depth++;
                                end
                            end else begin
                                if (pushed < MAX_NODES) begin
                                    post_order[pushed] = v;
                                    pushed++;
                                end
                                depth--;
                            end
                        end
                    end
                end
                // Emit top of the post-order stack first
                for (int k = 0; k < pushed; k++) begin
                    res.node_index    = NODE_W'(post_order[pushed - 1 - k]);
                    res.last_node     = (k + 1 == pushed);
                    res.edges_dropped = degree_overflow;
                    pending_order     = {pending_order, res};
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_order_result(input dfs_topo_pkg::t_out_item got);
        dfs_topo_pkg::t_out_item want;
        if (pending_order.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, actual node %0d last %0d drop %0d",
                     $time, got.node_index, got.last_node, got.edges_dropped);
        end else begin
            want = pending_order.pop_front();
            if (got.node_index !== want.node_index) begin
                mismatch_count++;
                $display("%0t: node_index expected %0d, actual %0d",
                         $time, want.node_index, got.node_index);
            end
            if (got.last_node !== want.last_node) begin
                mismatch_count++;
                $display("%0t: last_node expected %0d, actual %0d",
                         $time, want.last_node, got.last_node);
            end
            if (got.edges_dropped !== want.edges_dropped) begin
                mismatch_count++;
                $display("%0t: edges_dropped expected %0d, actual %0d",
                         $time, want.edges_dropped, got.edges_dropped);
            end
        end
    endfunction

    // Check each result transfer, then pick the stall for the next cycle
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) check_order_result(out_item);
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Offer one item, with random gaps ahead of it, and hold it until the transfer
    task automatic send_item(input dfs_topo_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic transfer_item(input dfs_topo_pkg::t_in_item it);
        send_item(it);
        apply_graph_command(it);
    endtask

    // Drop valid and wait until every predicted result has arrived
    task automatic wait_for_results(input int settle);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_order.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_node_count(input logic [NODE_COUNT_W-1:0] value);
        wait_for_results(SETTLE_CYCLES);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        nodes_in_use = int'(value);
    endtask

    // Mostly well-formed graph loads ending in a run, with some random noise items
    task automatic run_phase(input logic [NODE_COUNT_W-1:0] count, input int send_pct,
                             input int recv_pct, input int want_items,
                             input bit pause_midway, input int hold_cycles);
        int n_eff;
        int sent;
        int adds;
        int hub;
        bit paused;
        dfs_topo_pkg::t_in_item it;
        set_node_count(count);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        hold_request   = hold_cycles;
        n_eff  = (int'(count) > MAX_NODES) ? MAX_NODES : int'(count);
        sent   = 0;
        paused = 1'b0;
        while (sent < want_items) begin
            if (pause_midway && !paused && sent >= want_items / 2) begin
                paused = 1'b1;
                wait_for_results(0);
            end
            if ($urandom_range(99) < 80) begin
                if ($urandom_range(99) < 70) begin
                    transfer_item(make_item(dfs_topo_pkg::CMD_CLEAR,
                                            NODE_W'($urandom_range(63)),
                                            NODE_W'($urandom_range(63))));
                    sent++;
                end
                adds = $urandom_range((n_eff < 8) ? 3 * n_eff : 24);
                repeat (adds) begin
                    it = make_item(dfs_topo_pkg::CMD_ADD, NODE_W'($urandom_range(n_eff - 1)),
                                   NODE_W'($urandom_range(n_eff - 1)));
                    // Now and then point past the nodes in use
                    if ($urandom_range(9) == 0) it.to_node = NODE_W'($urandom_range(63));
                    transfer_item(it);
                    sent++;
                end
                // Occasionally fill one successor list to capacity or beyond
                if ($urandom_range(9) == 0) begin
                    hub = $urandom_range(n_eff - 1);
                    repeat ($urandom_range(11, 8)) begin
                        transfer_item(make_item(dfs_topo_pkg::CMD_ADD, NODE_W'(hub),
                                                NODE_W'($urandom_range(n_eff - 1))));
                        sent++;
                    end
                end
                transfer_item(make_item(dfs_topo_pkg::CMD_RUN, NODE_W'($urandom_range(63)),
                                        NODE_W'($urandom_range(63))));
                sent++;
            end else begin
                it = make_item(CMD_W'($urandom_range(3)), NODE_W'($urandom_range(63)),
                               NODE_W'($urandom_range(63)));
                transfer_item(it);
                if (it.command != UNUSED_CMD) sent++;
            end
        end
    endtask

    initial begin
        int queued;
        dfs_topo_pkg::t_out_item typed_res;

        for (int n = 0; n < MAX_NODES; n++) succ_count[n] = 0;

        // Directed steps; typed rows carry the order read straight off the graph
        dir_table[0]  = run_row(1'b0, 3'd0, '0, 1'b0);
        dir_table[1]  = cfg_row(7'd4);
        dir_table[2]  = run_row(1'b1, 3'd4, {6'd3, 6'd2, 6'd1, 6'd0}, 1'b0);
        dir_table[3]  = item_row(dfs_topo_pkg::CMD_ADD, 6'd0, 6'd1, 4'd1);
        dir_table[4]  = item_row(dfs_topo_pkg::CMD_ADD, 6'd1, 6'd2, 4'd1);
        dir_table[5]  = item_row(dfs_topo_pkg::CMD_ADD, 6'd2, 6'd3, 4'd1);
        dir_table[6]  = run_row(1'b1, 3'd4, {6'd0, 6'd1, 6'd2, 6'd3}, 1'b0);
        dir_table[7]  = item_row(dfs_topo_pkg::CMD_ADD, 6'd3, 6'd0, 4'd1);
        dir_table[8]  = item_row(dfs_topo_pkg::CMD_ADD, 6'd0, 6'd63, 4'd1);
        dir_table[9]  = run_row(1'b1, 3'd4, {6'd0, 6'd1, 6'd2, 6'd3}, 1'b0);
        dir_table[10] = item_row(UNUSED_CMD, 6'd63, 6'd63, 4'd1);
        dir_table[11] = item_row(dfs_topo_pkg::CMD_CLEAR, 6'd0, 6'd0, 4'd1);
        dir_table[12] = run_row(1'b1, 3'd4, {6'd3, 6'd2, 6'd1, 6'd0}, 1'b0);
        dir_table[13] = item_row(dfs_topo_pkg::CMD_ADD, 6'd2, 6'd3, 4'd9);
        dir_table[14] = run_row(1'b1, 3'd4, {6'd2, 6'd3, 6'd1, 6'd0}, 1'b1);
        dir_table[15] = cfg_row(7'd0);
        dir_table[16] = run_row(1'b1, 3'd0, '0, 1'b1);
        dir_table[17] = item_row(dfs_topo_pkg::CMD_ADD, 6'd63, 6'd0, 4'd1);
        dir_table[18] = cfg_row(7'd127);
        dir_table[19] = run_row(1'b0, 3'd0, '0, 1'b0);
        dir_table[20] = item_row(dfs_topo_pkg::CMD_CLEAR, 6'd63, 6'd63, 4'd1);
        dir_table[21] = cfg_row(7'd1);
        dir_table[22] = run_row(1'b1, 3'd1, '0, 1'b0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_table[r].kind == ROW_CFG) begin
                set_node_count(dir_table[r].cfg_value);
            end else begin
                repeat (int'(dir_table[r].reps)) begin
                    send_item(dir_table[r].item);
                    queued = pending_order.size();
                    apply_graph_command(dir_table[r].item);
                    if (dir_table[r].has_typed) begin
                        while (pending_order.size() > queued) void'(pending_order.pop_back());
                        for (int k = 0; k < int'(dir_table[r].typed_count); k++) begin
                            typed_res.node_index    = dir_table[r].typed_nodes[k];
                            typed_res.last_node     = (k + 1 == int'(dir_table[r].typed_count));
                            typed_res.edges_dropped = dir_table[r].typed_dropped;
                            pending_order           = {pending_order, typed_res};
                        end
                    end
                end
            end
        end

        // Random phases: node count, sender idle, receiver stall, items, pause, hold-off
        run_phase(7'd8,   0,  0,  50, 1'b0, 0);
        run_phase(7'd5,   61, 0,  50, 1'b1, 0);
        run_phase(7'd12,  0,  61, 50, 1'b0, 0);
        run_phase(7'd2,   13, 13, 40, 1'b0, 0);
        run_phase(7'd64,  13, 13, 40, 1'b0, 0);
        run_phase(7'd16,  0,  0,  50, 1'b0, 400);
        run_phase(7'd127, 0,  61, 25, 1'b0, 0);

        wait_for_results(DRAIN_CYCLES);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/dfs_topo_pkg.sv
design/dfs_topo_ram.sv
design/dfs_topological_sort_core.sv
design/dfs_topo_chk.sv
test/tb.sv
